[rtl/imh_pkg.sv]
package imh_pkg;

    localparam int DEF_MAX_VERTICES = 256;

    localparam int VTX_W   = 8;
    localparam int KEY_W   = 31;
    localparam int ENTRY_W = VTX_W + KEY_W;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_APPEND   = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT  = 2'd1;
    localparam logic [OP_W-1:0] OP_DECREASE = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic decide;
        logic up_rd;
        logic up_step;
        logic dn_rd;
        logic dn_step;
        logic place;
        logic out_load;
    } imh_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic op_decrease;
        logic go_up;
        logic go_down;
        logic up_move;
        logic dn_move;
        logic moved;
        logic out_free;
    } imh_stat_t;

endpackage

[rtl/imh_ctrl.sv]
module imh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  imh_pkg::imh_stat_t stat,
    output imh_pkg::imh_cmd_t  cmd
);
    import imh_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_UP_RD  = 4'd3;
    localparam logic [3:0] S_UP_CMP = 4'd4;
    localparam logic [3:0] S_DN_RD  = 4'd5;
    localparam logic [3:0] S_DN_CMP = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.go_up)
                begin
                    state_next = S_UP_RD;
                end
                else if (stat.go_down)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_UP_RD:
            begin
                cmd.up_rd  = 1'b1;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (stat.up_move)
                begin
                    cmd.up_step = 1'b1;
                    state_next  = S_UP_RD;
                end
                else if (stat.op_decrease && !stat.moved)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_DN_RD:
            begin
                cmd.dn_rd  = 1'b1;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (stat.dn_move)
                begin
                    cmd.dn_step = 1'b1;
                    state_next  = S_DN_RD;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

[rtl/imh_datapath.sv]
module imh_datapath #(
    parameter int MAX_VERTICES = imh_pkg::DEF_MAX_VERTICES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  imh_pkg::imh_cmd_t           cmd,
    output imh_pkg::imh_stat_t          stat,
    input  logic [imh_pkg::OP_W-1:0]    in_op,
    input  logic [imh_pkg::VTX_W-1:0]   in_vertex,
    input  logic [imh_pkg::KEY_W-1:0]   in_key,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [imh_pkg::STAT_W-1:0]  out_status,
    output logic [imh_pkg::VTX_W-1:0]   out_vertex,
    output logic [imh_pkg::KEY_W-1:0]   out_key,
    output logic                        out_present
);
    import imh_pkg::*;

    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CH_W  = IDX_W + 2;

    logic [ENTRY_W-1:0] heap_mem_reg [MAX_VERTICES];
    logic [CNT_W-1:0]   pos_mem_reg  [MAX_VERTICES];

    logic [ENTRY_W-1:0] rd_a_reg;
    logic [ENTRY_W-1:0] rd_b_reg;
    logic [CNT_W-1:0]   pos_rd_reg;

    logic [OP_W-1:0]    op_reg;
    logic [VTX_W-1:0]   vtx_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [IDX_W-1:0]   hole_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               moved_reg;
    logic [IDX_W-1:0]   clr_reg;

    logic [STAT_W-1:0]  res_status_reg;
    logic [VTX_W-1:0]   res_vtx_reg;
    logic [KEY_W-1:0]   res_key_reg;
    logic               res_present_reg;

    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [VTX_W-1:0]   out_vtx_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic               out_present_reg;

    logic               in_range;
    logic               held;
    logic               full;
    logic               empty;
    logic [IDX_W-1:0]   parent_idx;
    logic [CH_W-1:0]    left_w;
    logic [CH_W-1:0]    right_w;
    logic [CH_W-1:0]    cnt_w;
    logic               sel_l;
    logic               sel_r;
    logic [KEY_W-1:0]   best_key;
    logic [ENTRY_W-1:0] child;
    logic [IDX_W-1:0]   child_idx;
    logic [IDX_W-1:0]   rd_addr_a;
    logic [IDX_W-1:0]   rd_addr_b;
    logic               rd_en;
    logic               heap_we;
    logic [ENTRY_W-1:0] heap_wd;
    logic               pos_we;
    logic [IDX_W-1:0]   pos_wa;
    logic [CNT_W-1:0]   pos_wd;
    logic               ext_wr;
    logic [STAT_W-1:0]  dec_status;

    assign in_range = (32'(vtx_reg) < MAX_VERTICES);
    assign held     = in_range && (pos_rd_reg < cnt_reg);
    assign full     = (cnt_reg == CNT_W'(MAX_VERTICES));
    assign empty    = (cnt_reg == '0);

    assign parent_idx = IDX_W'((hole_reg - 1'b1) >> 1);
    assign left_w     = {1'b0, hole_reg, 1'b1};
    assign right_w    = left_w + CH_W'(1);
    assign cnt_w      = CH_W'(cnt_reg);

    assign sel_l     = (left_w < cnt_w) && (rd_a_reg[KEY_W-1:0] < key_reg);
    assign best_key  = sel_l ? rd_a_reg[KEY_W-1:0] : key_reg;
    assign sel_r     = (right_w < cnt_w) && (rd_b_reg[KEY_W-1:0] < best_key);
    assign child     = sel_r ? rd_b_reg : rd_a_reg;
    assign child_idx = sel_r ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

    assign stat.clr_last    = (clr_reg == IDX_W'(MAX_VERTICES - 1));
    assign stat.op_decrease = (op_reg == OP_DECREASE);
    assign stat.go_up       = ((op_reg == OP_APPEND) && in_range && !held && !full)
                           || ((op_reg == OP_DECREASE) && held);
    assign stat.go_down     = (op_reg == OP_EXTRACT) && (cnt_reg > CNT_W'(1));
    assign stat.up_move     = (hole_reg != '0) && (key_reg < rd_a_reg[KEY_W-1:0]);
    assign stat.dn_move     = sel_l || sel_r;
    assign stat.moved       = moved_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign rd_en     = cmd.load || cmd.up_rd || cmd.dn_rd;
    assign rd_addr_a = cmd.load ? '0 : (cmd.up_rd ? parent_idx : left_w[IDX_W-1:0]);
    assign rd_addr_b = cmd.load ? IDX_W'(cnt_reg - 1'b1) : right_w[IDX_W-1:0];

    assign ext_wr  = cmd.decide && (op_reg == OP_EXTRACT) && !empty;
    assign heap_we = cmd.up_step || cmd.dn_step || cmd.place;

    always_comb
    begin
        if (cmd.up_step)
        begin
            heap_wd = rd_a_reg;
        end
        else if (cmd.dn_step)
        begin
            heap_wd = child;
        end
        else
        begin
            heap_wd = {vtx_reg, key_reg};
        end
    end

    always_comb
    begin
        dec_status = ST_OK;
        unique case (op_reg)
            OP_APPEND:
            begin
                if (!in_range)
                begin
                    dec_status = ST_ABSENT;
                end
                else if (!held && full)
                begin
                    dec_status = ST_FULL;
                end
            end
            OP_EXTRACT:
            begin
                if (empty)
                begin
                    dec_status = ST_EMPTY;
                end
            end
            OP_DECREASE:
            begin
                if (!held)
                begin
                    dec_status = ST_ABSENT;
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    assign pos_we = cmd.clr_wr || ext_wr || heap_we;

    always_comb
    begin
        pos_wd = CNT_W'(hole_reg);
        if (cmd.clr_wr)
        begin
            pos_wa = clr_reg;
            pos_wd = CNT_W'(MAX_VERTICES);
        end
        else if (ext_wr)
        begin
            pos_wa = IDX_W'(rd_a_reg[ENTRY_W-1:KEY_W]);
            pos_wd = CNT_W'(MAX_VERTICES);
        end
        else if (cmd.up_step)
        begin
            pos_wa = IDX_W'(rd_a_reg[ENTRY_W-1:KEY_W]);
        end
        else if (cmd.dn_step)
        begin
            pos_wa = IDX_W'(child[ENTRY_W-1:KEY_W]);
        end
        else
        begin
            pos_wa = IDX_W'(vtx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem_reg[hole_reg] <= heap_wd;
        end
        if (rd_en)
        begin
            rd_a_reg <= heap_mem_reg[rd_addr_a];
            rd_b_reg <= heap_mem_reg[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem_reg[pos_wa] <= pos_wd;
        end
        if (cmd.load)
        begin
            pos_rd_reg <= pos_mem_reg[IDX_W'(in_vertex)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            clr_reg       <= '0;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.decide)
            begin
                moved_reg <= 1'b0;
                if ((op_reg == OP_APPEND) && stat.go_up)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else if (ext_wr)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else if (cmd.up_step)
            begin
                moved_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            vtx_reg <= in_vertex;
            key_reg <= in_key;
        end
        if (cmd.decide)
        begin
            res_status_reg  <= dec_status;
            res_vtx_reg     <= ext_wr ? rd_a_reg[ENTRY_W-1:KEY_W] : '0;
            res_key_reg     <= ext_wr ? rd_a_reg[KEY_W-1:0] : '0;
            res_present_reg <= (op_reg == OP_QUERY) && held;
            unique case (op_reg)
                OP_APPEND:
                begin
                    hole_reg <= IDX_W'(cnt_reg);
                end
                OP_EXTRACT:
                begin
                    if (!empty)
                    begin
                        vtx_reg <= rd_b_reg[ENTRY_W-1:KEY_W];
                        key_reg <= rd_b_reg[KEY_W-1:0];
                    end
                    hole_reg <= '0;
                end
                OP_DECREASE:
                begin
                    hole_reg <= IDX_W'(pos_rd_reg);
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.up_step)
        begin
            hole_reg <= parent_idx;
        end
        else if (cmd.dn_step)
        begin
            hole_reg <= child_idx;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_vtx_reg     <= res_vtx_reg;
            out_key_reg     <= res_key_reg;
            out_present_reg <= res_present_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_vertex  = out_vtx_reg;
    assign out_key     = out_key_reg;
    assign out_present = out_present_reg;

endmodule

[rtl/indexed_min_heap_unit.sv]
// Channel   Direction  tdata (lowest bit up)                       tuser
// s_axis    in         vertex[7:0], key_in[38:8], zero[39]         op[1:0]
// m_axis    out        vertex_out[7:0], key_out[38:8], present[39] status[1:0]
//
// Each operation is accepted in IDLE and decided in DECIDE, then walks the heap with
// a read state and a compare state per heap level, since each level waits on the
// registered read of the heap memory, and ends in FINISH. Decrease key walks up, and
// walks down only if it did not move up. Query and error cases skip the walk.
// After reset the position map is cleared entry by entry before s_tready rises.
// A new beat is accepted while the previous result still waits on m_tready.
module indexed_min_heap_unit #(
    parameter int MAX_VERTICES = imh_pkg::DEF_MAX_VERTICES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [imh_pkg::TDATA_W-1:0]   s_tdata,  // vertex, key_in, pad
    input  logic [imh_pkg::OP_W-1:0]      s_tuser,  // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [imh_pkg::TDATA_W-1:0]   m_tdata,  // vertex_out, key_out, present
    output logic [imh_pkg::STAT_W-1:0]    m_tuser   // status
);
    import imh_pkg::*;

    imh_cmd_t  cmd;
    imh_stat_t stat;

    logic [VTX_W-1:0] out_vertex;
    logic [KEY_W-1:0] out_key;
    logic             out_present;

    imh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    imh_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (s_tuser),
        .in_vertex   (s_tdata[VTX_W-1:0]),
        .in_key      (s_tdata[VTX_W+KEY_W-1:VTX_W]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_vertex  (out_vertex),
        .out_key     (out_key),
        .out_present (out_present)
    );

    assign m_tdata = {out_present, out_key, out_vertex};

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[VTX_W+KEY_W-1:0] == '0))
        else $error("error result carries a removed entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[VTX_W+KEY_W] |-> (m_tuser == ST_OK))
        else $error("present flag set with an error status");

endmodule

[dv/indexed_min_heap_unit_test.sv]
`timescale 1ns / 100ps

module indexed_min_heap_unit_test;
    import imh_pkg::*;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VTX_W-1:0] vertex;
        logic [KEY_W-1:0] key;
    } heap_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VTX_W-1:0]  vertex;
        logic [KEY_W-1:0]  key;
        logic              present;
    } heap_ans_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;

    heap_cmd_t pending_cmds[$];
    heap_ans_t expected_answers[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 87;
    bit stim_done = 0;

    logic [VTX_W-1:0] mdl_vtx[NV];
    logic [KEY_W-1:0] mdl_key[NV];
    int mdl_pos[NV];
    int mdl_count;

    indexed_min_heap_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    function automatic bit vertex_held(logic [VTX_W-1:0] v);
        return mdl_pos[v] < mdl_count;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [VTX_W-1:0] tv;
        logic [KEY_W-1:0] tk;
        tv = mdl_vtx[a];
        tk = mdl_key[a];
        mdl_vtx[a] = mdl_vtx[b];
        mdl_key[a] = mdl_key[b];
        mdl_vtx[b] = tv;
        mdl_key[b] = tk;
        mdl_pos[mdl_vtx[a]] = a;
        mdl_pos[mdl_vtx[b]] = b;
    endfunction

    function automatic int sift_up(int i);
        int p;
        while (i > 0 && i < mdl_count)
        begin
            p = (i - 1) / 2;
            if (!(mdl_key[i] < mdl_key[p]))
                break;
            swap_slots(i, p);
            i = p;
        end
        return i;
    endfunction

    function automatic void sift_down(int i);
        int l;
        int r;
        int s;
        while (i < mdl_count)
        begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            s = i;
            if (l < mdl_count && mdl_key[l] < mdl_key[s])
                s = l;
            if (r < mdl_count && mdl_key[r] < mdl_key[s])
                s = r;
            if (s == i)
                break;
            swap_slots(i, s);
            i = s;
        end
    endfunction

    function automatic heap_ans_t predict_heap_op(heap_cmd_t c);
        heap_ans_t a;
        int i;
        logic [VTX_W-1:0] lv;
        a = '0;
        a.status = ST_OK;
        case (c.op)
            OP_APPEND:
            begin
                if (vertex_held(c.vertex))
                    a.status = ST_OK;
                else if (mdl_count >= NV)
                    a.status = ST_FULL;
                else
                begin
                    i = mdl_count;
                    mdl_vtx[i] = c.vertex;
                    mdl_key[i] = c.key;
                    mdl_pos[c.vertex] = i;
                    mdl_count = i + 1;
                    void'(sift_up(i));
                end
            end
            OP_EXTRACT:
            begin
                if (mdl_count == 0)
                    a.status = ST_EMPTY;
                else
                begin
                    lv = mdl_vtx[mdl_count - 1];
                    a.vertex = mdl_vtx[0];
                    a.key = mdl_key[0];
                    mdl_vtx[0] = lv;
                    mdl_key[0] = mdl_key[mdl_count - 1];
                    mdl_count = mdl_count - 1;
                    mdl_pos[a.vertex] = NV;
                    if (mdl_count > 0)
                    begin
                        mdl_pos[lv] = 0;
                        sift_down(0);
                    end
                end
            end
            OP_DECREASE:
            begin
                if (!vertex_held(c.vertex))
                    a.status = ST_ABSENT;
                else
                begin
                    i = mdl_pos[c.vertex];
                    mdl_key[i] = c.key;
                    if (sift_up(i) == i)
                        sift_down(i);
                end
            end
            default:
                a.present = vertex_held(c.vertex);
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {KEY_W{1'b1}};
            2: return KEY_W'($urandom_range(0, 15));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    function automatic void add_cmd(logic [OP_W-1:0] op, logic [VTX_W-1:0] v,
                                    logic [KEY_W-1:0] k);
        heap_cmd_t c;
        c.op = op;
        c.vertex = v;
        c.key = k;
        pending_cmds.push_back(c);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_answers.push_back(predict_heap_op({s_tuser, s_tdata[7:0],
                                                            s_tdata[38:8]}));
            if (!(s_tvalid && !s_tready))
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    heap_cmd_t c;
                    c = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= c.op;
                    s_tdata <= {1'b0, c.key, c.vertex};
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected beat", m_tdata, 0);
                else
                begin
                    heap_ans_t w;
                    w = expected_answers.pop_front();
                    if (m_tuser !== w.status)
                        report_mismatch("status", m_tuser, w.status);
                    if (m_tdata[7:0] !== w.vertex)
                        report_mismatch("vertex_out", m_tdata[7:0], w.vertex);
                    if (m_tdata[38:8] !== w.key)
                        report_mismatch("key_out", m_tdata[38:8], w.key);
                    if (m_tdata[39] !== w.present)
                        report_mismatch("present", m_tdata[39], w.present);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int phase;
        int op_pick;
        for (int i = 0; i < NV; i++)
        begin
            mdl_pos[i] = NV;
            mdl_vtx[i] = '0;
            mdl_key[i] = '0;
        end
        mdl_count = 0;

        add_cmd(OP_EXTRACT, 8'd0, '0);
        add_cmd(OP_QUERY, 8'd255, '0);
        add_cmd(OP_DECREASE, 8'd7, 31'd5);
        add_cmd(OP_APPEND, 8'd255, {KEY_W{1'b1}});
        add_cmd(OP_APPEND, 8'd0, '0);
        add_cmd(OP_APPEND, 8'd0, 31'd9);
        add_cmd(OP_APPEND, 8'd10, 31'd3);
        add_cmd(OP_APPEND, 8'd11, 31'd3);
        add_cmd(OP_APPEND, 8'd12, 31'd3);
        add_cmd(OP_QUERY, 8'd255, '0);
        add_cmd(OP_DECREASE, 8'd0, {KEY_W{1'b1}});
        add_cmd(OP_DECREASE, 8'd255, 31'd1);
        add_cmd(OP_EXTRACT, 8'd0, '0);
        add_cmd(OP_EXTRACT, 8'd0, '0);
        add_cmd(OP_QUERY, 8'd10, '0);
        for (int i = 0; i < 5; i++)
            add_cmd(OP_EXTRACT, 8'd0, '0);
        add_cmd(OP_QUERY, 8'd0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++)
        begin
            // Random mix per phase; phase 1 first fills toward full and phase 2 ends with a drain.
            for (n = 0; n < 360; n++)
            begin
                op_pick = $urandom_range(0, 99);
                if (phase == 1 && n < 280)
                    add_cmd(OP_APPEND, VTX_W'(n), rand_key());
                else if (op_pick < 40)
                    add_cmd(OP_APPEND, VTX_W'($urandom), rand_key());
                else if (op_pick < 65)
                    add_cmd(OP_EXTRACT, VTX_W'($urandom), KEY_W'($urandom));
                else if (op_pick < 88)
                    add_cmd(OP_DECREASE, VTX_W'($urandom), rand_key());
                else
                    add_cmd(OP_QUERY, VTX_W'($urandom), KEY_W'($urandom));
            end
            if (phase == 2)
                for (n = 0; n < 260; n++)
                    add_cmd(OP_EXTRACT, 8'd0, '0);
            wait (pending_cmds.size() == 0 && !s_tvalid);
            wait (expected_answers.size() == 0);
            if (phase == 0)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end

        repeat (100) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
